@@ rtl/core/pat_pkg.sv @@
// Shared types, constants and register indexes for the paged address translator.
// No dependencies; every other file in rtl/core refers to it by scoped names.

package pat_pkg;

   localparam int PAGES  = 16;
   localparam int FRAMES = 32;

   localparam int PAGE_IDX_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int OPERATION_W    = 1;
   localparam int PAGE_NUMBER_W  = 4;
   localparam int FRAME_NUMBER_W = 5;
   localparam int ADDRESS_W      = 32;
   localparam int PHYS_ADDRESS_W = 33;
   localparam int PAGE_SIZE_W    = 16;
   localparam int PRODUCT_W      = FRAME_NUMBER_W + PAGE_SIZE_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 2'd1;

   localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET    = 16'd1024;
   localparam logic [ADDRESS_W-1:0]   BASE_ADDRESS_RESET = 32'd0;

   localparam logic [OPERATION_W-1:0] OP_MAP       = 1'b0;
   localparam logic [OPERATION_W-1:0] OP_TRANSLATE = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [OPERATION_W-1:0]    operation;
      logic [PAGE_NUMBER_W-1:0]  page_number;
      logic [FRAME_NUMBER_W-1:0] frame_number;
      logic [ADDRESS_W-1:0]      logical_address;
   } req_type;

   typedef struct packed {
      logic [PHYS_ADDRESS_W-1:0] physical_address;
      logic                      fault;
   } rsp_type;

   typedef struct packed {
      logic                      is_map;
      logic [PAGE_NUMBER_W-1:0]  page;
      logic [FRAME_NUMBER_W-1:0] frame;
      logic [ADDRESS_W-1:0]      laddr;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic [PAGE_SIZE_W-1:0] page_size;
      logic [ADDRESS_W-1:0]   base_address;
   } cfg_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_LOOKUP,
      BACK_SUM
   } back_state_type;

endpackage

@@ rtl/core/pat_front.sv @@
// Front end: takes request beats, drops map beats outside the table, and queues the rest.
// Depends on pat_pkg.

module pat_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  pat_pkg::req_type        req_payload,
   output pat_pkg::queue_head_type head,
   input  logic                    pop
);

   pat_pkg::entry_type                   slots_ff [pat_pkg::QUEUE_DEPTH];
   logic [pat_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pat_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pat_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                 accept, is_map, map_ok, push, do_pop;
   pat_pkg::entry_type                   new_entry;

   assign busy   = (count_ff == pat_pkg::QUEUE_CNT_W'(pat_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;
   assign is_map = (req_payload.operation == pat_pkg::OP_MAP);
   assign map_ok = (32'(req_payload.page_number) < 32'(pat_pkg::PAGES)) &&
                   (32'(req_payload.frame_number) < 32'(pat_pkg::FRAMES));
   assign push   = accept && (!is_map || map_ok);
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      new_entry.is_map = is_map;
      new_entry.page   = req_payload.page_number;
      new_entry.frame  = req_payload.frame_number;
      new_entry.laddr  = req_payload.logical_address;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

endmodule

@@ rtl/core/pat_divider.sv @@
// Restoring divider, one quotient bit per cycle, for logical address by page size.
// Depends on pat_pkg.

module pat_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pat_pkg::ADDRESS_W-1:0]     dividend,
   input  logic [pat_pkg::PAGE_SIZE_W-1:0]   divisor,
   output logic                              done,
   output logic [pat_pkg::ADDRESS_W-1:0]     quotient,
   output logic [pat_pkg::PAGE_SIZE_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(pat_pkg::ADDRESS_W + 1);

   logic [pat_pkg::ADDRESS_W-1:0]   quot_ff, quot_in;
   logic [pat_pkg::PAGE_SIZE_W-1:0] rem_ff, rem_in;
   logic [pat_pkg::PAGE_SIZE_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            run_ff, run_in;
   logic                            done_ff, done_in;
   logic [pat_pkg::PAGE_SIZE_W:0]   shifted, trial;
   logic                            ge;

   assign shifted = {rem_ff, quot_ff[pat_pkg::ADDRESS_W-1]};
   assign ge      = (shifted >= {1'b0, div_ff});
   assign trial   = shifted - {1'b0, div_ff};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         quot_in  = {quot_ff[pat_pkg::ADDRESS_W-2:0], ge};
         rem_in   = ge ? trial[pat_pkg::PAGE_SIZE_W-1:0] : shifted[pat_pkg::PAGE_SIZE_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(pat_pkg::ADDRESS_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/pat_back.sv @@
// Back end: page table, sequencer around the divider, frame multiply and final sum.
// Depends on pat_pkg and pat_divider.

module pat_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pat_pkg::cfg_type        cfg,
   input  pat_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_strobe,
   output pat_pkg::rsp_type        rsp_payload
);

   pat_pkg::back_state_type state_ff, state_in;

   logic                                present_ff [pat_pkg::PAGES];
   logic [pat_pkg::FRAME_NUMBER_W-1:0]  frame_ff   [pat_pkg::PAGES];

   logic                                table_we, div_start, div_done;
   logic [pat_pkg::PAGE_IDX_W-1:0]      wr_idx, rd_idx;
   logic [pat_pkg::ADDRESS_W-1:0]       quotient;
   logic [pat_pkg::PAGE_SIZE_W-1:0]     remainder;

   logic                                fault_ff, fault_in;
   logic [pat_pkg::PRODUCT_W-1:0]       product_ff, product_in;
   logic [pat_pkg::PAGE_SIZE_W-1:0]     disp_ff;
   logic                                strobe_ff, strobe_in;
   pat_pkg::rsp_type                    rsp_ff, rsp_in;

   pat_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (head.entry.laddr),
      .divisor   (cfg.page_size),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pat_pkg::BACK_IDLE: begin
            if (head.valid && !head.entry.is_map) begin
               state_in = pat_pkg::BACK_DIVIDE;
            end
         end
         pat_pkg::BACK_DIVIDE: begin
            if (div_done) begin
               state_in = pat_pkg::BACK_LOOKUP;
            end
         end
         pat_pkg::BACK_LOOKUP: state_in = pat_pkg::BACK_SUM;
         pat_pkg::BACK_SUM:    state_in = pat_pkg::BACK_IDLE;
         default:              state_in = pat_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      table_we  = 1'b0;
      div_start = 1'b0;
      strobe_in = 1'b0;
      case (state_ff)
         pat_pkg::BACK_IDLE: begin
            pop       = head.valid;
            table_we  = head.valid && head.entry.is_map;
            div_start = head.valid && !head.entry.is_map;
         end
         pat_pkg::BACK_SUM: strobe_in = 1'b1;
         default: ;
      endcase
   end

   assign wr_idx = pat_pkg::PAGE_IDX_W'(head.entry.page);
   assign rd_idx = pat_pkg::PAGE_IDX_W'(quotient);

   // lookup stage: out of table or absent page faults
   always_comb begin
      fault_in   = (quotient >= pat_pkg::ADDRESS_W'(pat_pkg::PAGES)) || !present_ff[rd_idx];
      product_in = pat_pkg::PRODUCT_W'(frame_ff[rd_idx]) *
                   pat_pkg::PRODUCT_W'(cfg.page_size);
   end

   always_comb begin
      rsp_in.fault            = fault_ff;
      rsp_in.physical_address = fault_ff ? '0 :
         pat_pkg::PHYS_ADDRESS_W'(cfg.base_address) +
         pat_pkg::PHYS_ADDRESS_W'(product_ff) +
         pat_pkg::PHYS_ADDRESS_W'(disp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pat_pkg::BACK_IDLE;
         strobe_ff <= 1'b0;
         for (int i = 0; i < pat_pkg::PAGES; i++) begin
            present_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (table_we) begin
            present_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         frame_ff[wr_idx] <= head.entry.frame;
      end
      if (state_ff == pat_pkg::BACK_LOOKUP) begin
         fault_ff   <= fault_in;
         product_ff <= product_in;
         disp_ff    <= remainder;
      end
      if (strobe_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/paged_address_translator.sv @@
// Top level of the paged address translator: configuration registers, front end and back end.
// Depends on pat_pkg, pat_front, pat_back.
//
// A request beat is taken on a clock edge with start high and busy low; busy rises only when
// the two-entry queue between the front and back ends is full. A map beat is written to the
// page table as it leaves the queue and gives no result. A translate beat runs through the
// 32-step serial divider by page_size, then table lookup with the frame multiply, the final
// add and the output register; no further beat leaves the queue before its result is shown.
// Each result is shown for one cycle with rsp_strobe and cannot be held off; it must be taken
// then. Pages at or beyond the table, absent pages and a zero page size give fault with a zero
// address. Configuration writes are always ready and must only be made while no item is in
// flight.

module paged_address_translator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pat_pkg::req_type                  req_payload,
   output logic                              rsp_strobe,
   output pat_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pat_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pat_pkg::CSR_DATA_W-1:0]    csr_data
);

   pat_pkg::cfg_type        cfg_ff;
   pat_pkg::queue_head_type head;
   logic                    pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_size    <= pat_pkg::PAGE_SIZE_RESET;
         cfg_ff.base_address <= pat_pkg::BASE_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pat_pkg::CSR_PAGE_SIZE:
               cfg_ff.page_size <= csr_data[pat_pkg::PAGE_SIZE_W-1:0];
            pat_pkg::CSR_BASE_ADDRESS:
               cfg_ff.base_address <= csr_data[pat_pkg::ADDRESS_W-1:0];
            default: ;
         endcase
      end
   end

   pat_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   pat_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/core/pat_checker.sv @@
// Port-level checks for the paged address translator, bound to the top level.
// Depends on pat_pkg and paged_address_translator.

module pat_port_checks (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             rsp_strobe,
   input  pat_pkg::rsp_type rsp_payload
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.fault) |-> (rsp_payload.physical_address == '0))
      else $error("faulted result carries a non-zero address");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted beat");

   a_idle_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (!busy && !rsp_strobe))
      else $error("not idle after reset");

endmodule

bind paged_address_translator pat_port_checks u_pat_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
